[rtl/core/sgr_pkg.sv]
// shared types, constants and helpers for the shape and glyph rasteriser
// no dependencies; used by sgr_front, sgr_back and the top level

package sgr_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 512;
    localparam int GLYPH_COUNT = 128;

    localparam int XB        = $clog2(MAX_WIDTH);
    localparam int YB        = $clog2(MAX_HEIGHT);
    localparam int BIT_AW    = 6;
    localparam int WORD_AW   = XB + YB - BIT_AW;
    localparam int GLYPH_AW  = $clog2(GLYPH_COUNT);
    localparam int CW        = 22;
    localparam int SQW       = 24;

    localparam logic [10:0] MAX_W_VAL = 11'(MAX_WIDTH);
    localparam logic [9:0]  MAX_H_VAL = 10'(MAX_HEIGHT);

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [6:0]  FALLBACK_CHAR = 7'h3f;

    localparam logic [2:0] REQ_CLEAR  = 3'd0;
    localparam logic [2:0] REQ_RECT   = 3'd1;
    localparam logic [2:0] REQ_CIRCLE = 3'd2;
    localparam logic [2:0] REQ_CHAR   = 3'd3;
    localparam logic [2:0] REQ_LOAD   = 3'd4;
    localparam logic [2:0] REQ_READ   = 3'd5;
    localparam logic [2:0] REQ_HASH   = 3'd6;

    typedef struct packed {
        logic [2:0]         req;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic [10:0]        size_a;
        logic [10:0]        size_b;
        logic [6:0]         char_code;
        logic [6:0]         char_slot;
        logic [2:0]         row_idx;
        logic [7:0]         row_bits;
        logic [7:0]         scale;
        logic signed [12:0] top;
    } cmd_t;

    typedef struct packed {
        logic        pixel_value;
        logic [63:0] canvas_hash;
        logic        status;
    } res_t;

    // fnv-1a step on one byte holding 0 or 1; prime is 2^40 + 0x1b3
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic b);
        logic [63:0] t;
        t = h ^ {63'd0, b};
        return (t << 40) + (t << 8) + (t << 7) + (t << 5) + (t << 4) + (t << 1) + t;
    endfunction

endpackage

[rtl/core/sgr_front.sv]
// front end: accepts items, works out scale and top edge and holds them in a two-entry queue
// depends on sgr_pkg

module sgr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [2:0]          req_type,
    input  logic signed [11:0]  pos_x,
    input  logic signed [11:0]  pos_y,
    input  logic [10:0]         size_a,
    input  logic [10:0]         size_b,
    input  logic [6:0]          char_code,
    input  logic [6:0]          char_slot,
    input  logic [2:0]          glyph_row_index,
    input  logic [7:0]          glyph_row_bits,
    output logic                cmd_valid,
    input  logic                cmd_take,
    output sgr_pkg::cmd_t       cmd
);

    sgr_pkg::cmd_t q_mem [2];
    sgr_pkg::cmd_t in_cmd;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    // scale and top edge worked out once on entry
    always_comb
    begin
        in_cmd.req       = req_type;
        in_cmd.pos_x     = pos_x;
        in_cmd.pos_y     = pos_y;
        in_cmd.size_a    = size_a;
        in_cmd.size_b    = size_b;
        in_cmd.char_code = char_code;
        in_cmd.char_slot = char_slot;
        in_cmd.row_idx   = glyph_row_index;
        in_cmd.row_bits  = glyph_row_bits;
        in_cmd.scale     = (size_a[10:3] == 8'd0) ? 8'd1 : size_a[10:3];
        in_cmd.top       = $signed({pos_y[11], pos_y}) - $signed({2'b00, size_a});
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[rtl/core/sgr_back.sv]
// back end: sequencer that carries out one item at a time on the canvas and glyph stores
// depends on sgr_pkg

module sgr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [10:0]         act_w,
    input  logic [9:0]          act_h,
    input  logic                cmd_valid,
    output logic                cmd_take,
    input  sgr_pkg::cmd_t       cmd_in,
    output logic                res_valid,
    input  logic                res_take,
    output sgr_pkg::res_t       res
);

    localparam int CW  = sgr_pkg::CW;
    localparam int SQW = sgr_pkg::SQW;

    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_CLEAR  = 4'd2;
    localparam logic [3:0] ST_BOX    = 4'd3;
    localparam logic [3:0] ST_SWEEP  = 4'd4;
    localparam logic [3:0] ST_DISC_A = 4'd5;
    localparam logic [3:0] ST_DISC_B = 4'd6;
    localparam logic [3:0] ST_CHAR_A = 4'd7;
    localparam logic [3:0] ST_CHAR_B = 4'd8;
    localparam logic [3:0] ST_GBIT   = 4'd9;
    localparam logic [3:0] ST_GADV   = 4'd10;
    localparam logic [3:0] ST_READ   = 4'd11;
    localparam logic [3:0] ST_HASH   = 4'd12;
    localparam logic [3:0] ST_DONE   = 4'd13;

    // stores
    logic [63:0] canvas_mem [2**sgr_pkg::WORD_AW];
    logic [63:0] glyph_mem  [sgr_pkg::GLYPH_COUNT];
    logic [63:0] cv_rdata_reg;
    logic [63:0] gl_rdata_reg;

    logic                             cv_clr_we, cv_bit_we, cv_re;
    logic [sgr_pkg::WORD_AW-1:0]      cv_waddr, cv_raddr;
    logic [sgr_pkg::BIT_AW-1:0]       cv_wbit;
    logic                             gl_clr_we, gl_row_we, gl_re;
    logic [sgr_pkg::GLYPH_AW-1:0]     gl_waddr, gl_raddr;
    logic [2:0]                       gl_row;
    logic [7:0]                       gl_data;

    // control
    logic [3:0]                       state_reg, state_next;
    logic [sgr_pkg::WORD_AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [sgr_pkg::GLYPH_COUNT-1:0]  present_reg, present_next;
    logic                             iss_reg, iss_next;
    logic                             hv_reg, hv_next;
    logic                             hl_reg, hl_next;
    logic                             from_char_reg, from_char_next;
    logic                             disc_reg, disc_next;

    // payload
    sgr_pkg::cmd_t                    cmd_reg, cmd_next;
    logic signed [CW-1:0]             xx_reg, xx_next, yy_reg, yy_next;
    logic signed [CW-1:0]             x0_reg, x0_next, xl_reg, xl_next, yl_reg, yl_next;
    logic signed [CW-1:0]             bx_reg, bx_next, by_reg, by_next;
    logic signed [CW-1:0]             left_reg, left_next;
    logic [10:0]                      bw_reg, bw_next, bh_reg, bh_next;
    logic signed [12:0]               dx_reg, dx_next, dy_reg, dy_next, dx0_reg, dx0_next;
    logic [SQW-1:0]                   sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [SQW-1:0]                   sqx0_reg, sqx0_next, rr_reg, rr_next;
    logic [63:0]                      gbits_reg, gbits_next;
    logic [5:0]                       gcnt_reg, gcnt_next;
    logic [14:0]                      prod_reg, prod_next;
    logic [5:0]                       hb_reg, hb_next;
    logic [63:0]                      h_reg, h_next;
    logic                             pv_reg, pv_next;
    logic                             st_reg, st_next;

    // combinational helpers
    logic signed [CW-1:0]             aw_s, ah_s;
    logic signed [CW-1:0]             in_x, in_y, cx, cy, rad;
    logic signed [CW-1:0]             b_xe, b_ye, b_x0, b_y0, b_xl, b_yl;
    logic signed [CW-1:0]             d_x0, d_y0, d_xl, d_yl, d_xa, d_ya, d_xb, d_yb;
    logic signed [SQW:0]              step_x, step_y;
    logic [SQW:0]                     dsum;
    logic                             in_disc, last_x, last_y, in_range;
    logic [sgr_pkg::WORD_AW-1:0]      pix_addr;

    assign aw_s = $signed({{(CW-11){1'b0}}, act_w});
    assign ah_s = $signed({{(CW-10){1'b0}}, act_h});
    assign in_x = CW'(cmd_in.pos_x);
    assign in_y = CW'(cmd_in.pos_y);
    assign cx   = CW'(cmd_reg.pos_x);
    assign cy   = CW'(cmd_reg.pos_y);
    assign rad  = $signed({{(CW-11){1'b0}}, cmd_reg.size_a});

    assign pix_addr = {yy_reg[sgr_pkg::YB-1:0], xx_reg[sgr_pkg::XB-1:sgr_pkg::BIT_AW]};

    // box clipping, end exclusive before the final minus one
    always_comb
    begin
        b_xe = bx_reg + $signed({{(CW-11){1'b0}}, bw_reg});
        b_ye = by_reg + $signed({{(CW-11){1'b0}}, bh_reg});
        b_x0 = (bx_reg < 0) ? '0 : bx_reg;
        b_y0 = (by_reg < 0) ? '0 : by_reg;
        b_xl = ((b_xe > aw_s) ? aw_s : b_xe) - CW'(1);
        b_yl = ((b_ye > ah_s) ? ah_s : b_ye) - CW'(1);
    end

    // disc bounding box, inclusive
    always_comb
    begin
        d_xa = cx - rad;
        d_ya = cy - rad;
        d_xb = cx + rad;
        d_yb = cy + rad;
        d_x0 = (d_xa < 0) ? '0 : d_xa;
        d_y0 = (d_ya < 0) ? '0 : d_ya;
        d_xl = (d_xb > aw_s - CW'(1)) ? aw_s - CW'(1) : d_xb;
        d_yl = (d_yb > ah_s - CW'(1)) ? ah_s - CW'(1) : d_yb;
    end

    assign step_x  = {{(SQW-13){dx_reg[12]}}, dx_reg, 1'b1};
    assign step_y  = {{(SQW-13){dy_reg[12]}}, dy_reg, 1'b1};
    assign dsum    = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign in_disc = !disc_reg || (dsum <= {1'b0, rr_reg});
    assign last_x  = (xx_reg == xl_reg);
    assign last_y  = (yy_reg == yl_reg);
    assign in_range = (in_x >= 0) && (in_y >= 0) && (in_x < aw_s) && (in_y < ah_s);

    assign res_valid       = (state_reg == ST_DONE);
    assign res.pixel_value = pv_reg;
    assign res.canvas_hash = h_reg;
    assign res.status      = st_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        present_next   = present_reg;
        iss_next       = iss_reg;
        hv_next        = hv_reg;
        hl_next        = hl_reg;
        from_char_next = from_char_reg;
        disc_next      = disc_reg;
        cmd_next       = cmd_reg;
        xx_next        = xx_reg;
        yy_next        = yy_reg;
        x0_next        = x0_reg;
        xl_next        = xl_reg;
        yl_next        = yl_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        left_next      = left_reg;
        bw_next        = bw_reg;
        bh_next        = bh_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dx0_next       = dx0_reg;
        sqx_next       = sqx_reg;
        sqy_next       = sqy_reg;
        sqx0_next      = sqx0_reg;
        rr_next        = rr_reg;
        gbits_next     = gbits_reg;
        gcnt_next      = gcnt_reg;
        prod_next      = prod_reg;
        hb_next        = hb_reg;
        h_next         = h_reg;
        pv_next        = pv_reg;
        st_next        = st_reg;

        cmd_take  = 1'b0;
        cv_clr_we = 1'b0;
        cv_bit_we = 1'b0;
        cv_re     = 1'b0;
        cv_waddr  = pix_addr;
        cv_raddr  = pix_addr;
        cv_wbit   = xx_reg[sgr_pkg::BIT_AW-1:0];
        gl_clr_we = 1'b0;
        gl_row_we = 1'b0;
        gl_re     = 1'b0;
        gl_waddr  = cmd_in.char_code;
        gl_raddr  = cmd_in.char_code;
        gl_row    = cmd_in.row_idx;
        gl_data   = cmd_in.row_bits;

        case (state_reg)
            ST_INIT:
            begin
                cv_clr_we    = 1'b1;
                cv_waddr     = clr_cnt_reg;
                gl_clr_we    = (clr_cnt_reg[sgr_pkg::WORD_AW-1:sgr_pkg::GLYPH_AW] == '0);
                gl_waddr     = clr_cnt_reg[sgr_pkg::GLYPH_AW-1:0];
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take       = 1'b1;
                    cmd_next       = cmd_in;
                    h_next         = '0;
                    pv_next        = 1'b0;
                    st_next        = 1'b0;
                    from_char_next = 1'b0;
                    disc_next      = 1'b0;
                    case (cmd_in.req)
                        sgr_pkg::REQ_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        sgr_pkg::REQ_RECT:
                        begin
                            bx_next    = in_x;
                            by_next    = in_y;
                            bw_next    = cmd_in.size_a;
                            bh_next    = cmd_in.size_b;
                            state_next = ST_BOX;
                        end
                        sgr_pkg::REQ_CIRCLE:
                        begin
                            state_next = ST_DISC_A;
                        end
                        sgr_pkg::REQ_CHAR:
                        begin
                            gl_re      = 1'b1;
                            gl_raddr   = present_reg[cmd_in.char_code] ? cmd_in.char_code
                                                                       : sgr_pkg::FALLBACK_CHAR;
                            state_next = ST_CHAR_A;
                        end
                        sgr_pkg::REQ_LOAD:
                        begin
                            gl_row_we                      = 1'b1;
                            present_next[cmd_in.char_code] = 1'b1;
                            state_next                     = ST_DONE;
                        end
                        sgr_pkg::REQ_READ:
                        begin
                            if (in_range)
                            begin
                                cv_re      = 1'b1;
                                cv_raddr   = {in_y[sgr_pkg::YB-1:0],
                                              in_x[sgr_pkg::XB-1:sgr_pkg::BIT_AW]};
                                hb_next    = in_x[sgr_pkg::BIT_AW-1:0];
                                state_next = ST_READ;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        sgr_pkg::REQ_HASH:
                        begin
                            if (act_w == 11'd0 || act_h == 10'd0)
                            begin
                                st_next    = 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                h_next     = sgr_pkg::FNV_BASIS;
                                xx_next    = '0;
                                yy_next    = '0;
                                xl_next    = aw_s - CW'(1);
                                yl_next    = ah_s - CW'(1);
                                iss_next   = 1'b1;
                                hv_next    = 1'b0;
                                state_next = ST_HASH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_CLEAR:
            begin
                cv_clr_we    = 1'b1;
                cv_waddr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_BOX:
            begin
                if (b_xl < b_x0 || b_yl < b_y0)
                begin
                    state_next = from_char_reg ? ST_GADV : ST_DONE;
                end
                else
                begin
                    xx_next    = b_x0;
                    yy_next    = b_y0;
                    x0_next    = b_x0;
                    xl_next    = b_xl;
                    yl_next    = b_yl;
                    state_next = ST_SWEEP;
                end
            end

            ST_DISC_A:
            begin
                if (d_xl < d_x0 || d_yl < d_y0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    xx_next    = d_x0;
                    yy_next    = d_y0;
                    x0_next    = d_x0;
                    xl_next    = d_xl;
                    yl_next    = d_yl;
                    dx0_next   = 13'(d_x0 - cx);
                    dx_next    = 13'(d_x0 - cx);
                    dy_next    = 13'(d_y0 - cy);
                    disc_next  = 1'b1;
                    state_next = ST_DISC_B;
                end
            end

            ST_DISC_B:
            begin
                sqx0_next  = SQW'($unsigned(26'(dx_reg) * 26'(dx_reg)));
                sqx_next   = SQW'($unsigned(26'(dx_reg) * 26'(dx_reg)));
                sqy_next   = SQW'($unsigned(26'(dy_reg) * 26'(dy_reg)));
                rr_next    = SQW'(cmd_reg.size_a) * SQW'(cmd_reg.size_a);
                state_next = ST_SWEEP;
            end

            ST_SWEEP:
            begin
                cv_bit_we = in_disc;
                if (last_x)
                begin
                    xx_next  = x0_reg;
                    dx_next  = dx0_reg;
                    sqx_next = sqx0_reg;
                    if (last_y)
                    begin
                        state_next = from_char_reg ? ST_GADV : ST_DONE;
                    end
                    else
                    begin
                        yy_next  = yy_reg + CW'(1);
                        dy_next  = dy_reg + 13'sd1;
                        sqy_next = sqy_reg + step_y[SQW-1:0];
                    end
                end
                else
                begin
                    xx_next  = xx_reg + CW'(1);
                    dx_next  = dx_reg + 13'sd1;
                    sqx_next = sqx_reg + step_x[SQW-1:0];
                end
            end

            ST_CHAR_A:
            begin
                gbits_next = gl_rdata_reg;
                prod_next  = 15'(cmd_reg.char_slot) * 15'(cmd_reg.scale);
                state_next = ST_CHAR_B;
            end

            ST_CHAR_B:
            begin
                left_next      = cx + $signed({{(CW-18){1'b0}}, prod_reg, 3'b000});
                bx_next        = cx + $signed({{(CW-18){1'b0}}, prod_reg, 3'b000});
                by_next        = CW'(cmd_reg.top);
                bw_next        = {3'b000, cmd_reg.scale};
                bh_next        = {3'b000, cmd_reg.scale};
                gcnt_next      = '0;
                from_char_next = 1'b1;
                state_next     = ST_GBIT;
            end

            ST_GBIT:
            begin
                // row r sits in byte r, leftmost column in its top bit
                if (gbits_reg[{gcnt_reg[5:3], ~gcnt_reg[2:0]}])
                begin
                    state_next = ST_BOX;
                end
                else
                begin
                    state_next = ST_GADV;
                end
            end

            ST_GADV:
            begin
                if (&gcnt_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    gcnt_next = gcnt_reg + 6'd1;
                    if (&gcnt_reg[2:0])
                    begin
                        bx_next = left_reg;
                        by_next = by_reg + $signed({{(CW-8){1'b0}}, cmd_reg.scale});
                    end
                    else
                    begin
                        bx_next = bx_reg + $signed({{(CW-8){1'b0}}, cmd_reg.scale});
                    end
                    state_next = ST_GBIT;
                end
            end

            ST_READ:
            begin
                pv_next    = cv_rdata_reg[hb_reg];
                state_next = ST_DONE;
            end

            ST_HASH:
            begin
                // each read is issued in the cycle before its hash update
                hv_next = iss_reg;
                if (iss_reg)
                begin
                    cv_re   = 1'b1;
                    hb_next = xx_reg[sgr_pkg::BIT_AW-1:0];
                    hl_next = last_x && last_y;
                    if (last_x)
                    begin
                        xx_next = '0;
                        yy_next = yy_reg + CW'(1);
                        if (last_y)
                        begin
                            iss_next = 1'b0;
                        end
                    end
                    else
                    begin
                        xx_next = xx_reg + CW'(1);
                    end
                end
                if (hv_reg)
                begin
                    h_next = sgr_pkg::fnv_step(h_reg, cv_rdata_reg[hb_reg]);
                    if (hl_reg)
                    begin
                        hv_next    = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_cnt_reg   <= '0;
            present_reg   <= '0;
            iss_reg       <= 1'b0;
            hv_reg        <= 1'b0;
            hl_reg        <= 1'b0;
            from_char_reg <= 1'b0;
            disc_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            present_reg   <= present_next;
            iss_reg       <= iss_next;
            hv_reg        <= hv_next;
            hl_reg        <= hl_next;
            from_char_reg <= from_char_next;
            disc_reg      <= disc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        xx_reg    <= xx_next;
        yy_reg    <= yy_next;
        x0_reg    <= x0_next;
        xl_reg    <= xl_next;
        yl_reg    <= yl_next;
        bx_reg    <= bx_next;
        by_reg    <= by_next;
        left_reg  <= left_next;
        bw_reg    <= bw_next;
        bh_reg    <= bh_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        dx0_reg   <= dx0_next;
        sqx_reg   <= sqx_next;
        sqy_reg   <= sqy_next;
        sqx0_reg  <= sqx0_next;
        rr_reg    <= rr_next;
        gbits_reg <= gbits_next;
        gcnt_reg  <= gcnt_next;
        prod_reg  <= prod_next;
        hb_reg    <= hb_next;
        h_reg     <= h_next;
        pv_reg    <= pv_next;
        st_reg    <= st_next;
    end

    // canvas store, 64 pixels a word, bit-writable
    always_ff @(posedge clk)
    begin
        if (cv_clr_we)
        begin
            canvas_mem[cv_waddr] <= '0;
        end
        else if (cv_bit_we)
        begin
            canvas_mem[cv_waddr][cv_wbit] <= 1'b1;
        end
        if (cv_re)
        begin
            cv_rdata_reg <= canvas_mem[cv_raddr];
        end
    end

    // glyph store, one 64-bit word a glyph, byte-writable by row
    always_ff @(posedge clk)
    begin
        if (gl_clr_we)
        begin
            glyph_mem[gl_waddr] <= '0;
        end
        else if (gl_row_we)
        begin
            glyph_mem[gl_waddr][{gl_row, 3'b000} +: 8] <= gl_data;
        end
        if (gl_re)
        begin
            gl_rdata_reg <= glyph_mem[gl_raddr];
        end
    end

endmodule

[rtl/core/shape_and_glyph_rasterizer_core.sv]
// top level of the one-bit canvas rasteriser: config port, front queue, back sequencer
// depends on sgr_pkg, sgr_front and sgr_back
//
// usage
// - items go in through a queue-style port: an item is taken at a clock edge with push
//   high and full low; the front holds up to two items, so the source can run ahead
// - every item gives exactly one result item, in order, on the result ports while
//   empty is low; it is taken at an edge with pop high
// - the result sits in an output register, so the back sequencer moves on to the next
//   item as soon as that register is free; a stalled receiver only holds the back end
//   once the register is full, and the front keeps taking items until it is full too
// - canvas_width and canvas_height are written over the apb-style port at byte
//   addresses 0 and 4; the user must write them only while the block is idle, which
//   the block itself does not enforce; values above the canvas size are clipped to it
// - per item work: rect and char sweep one pixel a cycle over the clipped area
//   (char: 64 glyph-bit steps plus a sweep of each set square); disc sweeps its
//   clipped bounding box; clear writes the canvas one 64-pixel word a cycle;
//   hash walks all width*height pixels of the active area
// - the canvas store has one write port and one read port
// - after reset a clearing pass zeroes the canvas and glyph stores;
//   items are queued but not started until it ends

module shape_and_glyph_rasterizer_core (
    input  logic               clk,
    input  logic               rst_n,
    // apb-style configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // item input
    input  logic               push,
    output logic               full,
    input  logic [2:0]         req_type,
    input  logic signed [11:0] pos_x,
    input  logic signed [11:0] pos_y,
    input  logic [10:0]        size_a,
    input  logic [10:0]        size_b,
    input  logic [6:0]         char_code,
    input  logic [6:0]         char_slot,
    input  logic [2:0]         glyph_row_index,
    input  logic [7:0]         glyph_row_bits,
    // result output
    output logic               empty,
    input  logic               pop,
    output logic               pixel_value,
    output logic [63:0]        canvas_hash,
    output logic               status
);

    logic [10:0]        width_reg;
    logic [9:0]         height_reg;
    logic [10:0]        act_w;
    logic [9:0]         act_h;
    logic               cfg_wr;

    logic               cmd_valid;
    logic               cmd_take;
    sgr_pkg::cmd_t      cmd;
    logic               res_valid;
    logic               res_take;
    sgr_pkg::res_t      res;

    logic               out_valid_reg, out_valid_next;
    sgr_pkg::res_t      out_reg;

    // config registers; paddr bit 2 picks the register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {22'd0, height_reg} : {21'd0, width_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
            begin
                height_reg <= pwdata[9:0];
            end
            else
            begin
                width_reg <= pwdata[10:0];
            end
        end
    end

    // active area, saturated at the store size
    assign act_w = (width_reg > sgr_pkg::MAX_W_VAL) ? sgr_pkg::MAX_W_VAL : width_reg;
    assign act_h = (height_reg > sgr_pkg::MAX_H_VAL) ? sgr_pkg::MAX_H_VAL : height_reg;

    sgr_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .req_type        (req_type),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .size_a          (size_a),
        .size_b          (size_b),
        .char_code       (char_code),
        .char_slot       (char_slot),
        .glyph_row_index (glyph_row_index),
        .glyph_row_bits  (glyph_row_bits),
        .cmd_valid       (cmd_valid),
        .cmd_take        (cmd_take),
        .cmd             (cmd)
    );

    sgr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .act_w     (act_w),
        .act_h     (act_h),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd_in    (cmd),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // output register: refilled in the same cycle it is popped
    assign res_take = res_valid && (!out_valid_reg || pop);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign empty       = !out_valid_reg;
    assign pixel_value = out_reg.pixel_value;
    assign canvas_hash = out_reg.canvas_hash;
    assign status      = out_reg.status;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// self-checking testbench for shape_and_glyph_rasterizer_core
// holds its own canvas/glyph predictor and drives the block through its queue ports
// depends on sgr_pkg and the core rtl only

module tb_top;

    // unused request code, must give an all-zero result and no effect
    localparam logic [2:0] REQ_IDLE_CODE = 3'd7;
    localparam logic [2:0] ADDR_WIDTH_REG = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT_REG = 3'd4;
    localparam int STALL_LIMIT = 2000000;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        logic [2:0]         req;
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic [10:0]        sa;
        logic [10:0]        sb;
        logic [6:0]         code;
        logic [6:0]         slot;
        logic [2:0]         row;
        logic [7:0]         bits;
    } draw_item_t;

    // canvas predictor plus the queue of results still owed by the block
    class canvas_scoreboard;
        bit              pix [sgr_pkg::MAX_HEIGHT*sgr_pkg::MAX_WIDTH];
        bit [7:0]        glyph [sgr_pkg::GLYPH_COUNT*8];
        bit              loaded [sgr_pkg::GLYPH_COUNT];
        int              reg_w;
        int              reg_h;
        sgr_pkg::res_t   owed_q[$];
        int              errors;

        function int act_w();
            return reg_w > sgr_pkg::MAX_WIDTH ? sgr_pkg::MAX_WIDTH : reg_w;
        endfunction

        function int act_h();
            return reg_h > sgr_pkg::MAX_HEIGHT ? sgr_pkg::MAX_HEIGHT : reg_h;
        endfunction

        function void fill_box(int x, int y, int w, int h);
            int x0, y0, x1, y1;
            x0 = x < 0 ? 0 : x;
            y0 = y < 0 ? 0 : y;
            x1 = x + w;
            y1 = y + h;
            if (x1 > act_w()) x1 = act_w();
            if (y1 > act_h()) y1 = act_h();
            for (int yy = y0; yy < y1; yy++)
                for (int xx = x0; xx < x1; xx++)
                    pix[yy*sgr_pkg::MAX_WIDTH + xx] = 1'b1;
        endfunction

        function void fill_disc(int cx, int cy, int r);
            int x0, x1, y0, y1;
            x0 = cx - r < 0 ? 0 : cx - r;
            y0 = cy - r < 0 ? 0 : cy - r;
            x1 = cx + r > act_w() - 1 ? act_w() - 1 : cx + r;
            y1 = cy + r > act_h() - 1 ? act_h() - 1 : cy + r;
            for (int yy = y0; yy <= y1; yy++)
                for (int xx = x0; xx <= x1; xx++)
                    if ((xx-cx)*(xx-cx) + (yy-cy)*(yy-cy) <= r*r)
                        pix[yy*sgr_pkg::MAX_WIDTH + xx] = 1'b1;
        endfunction

        function void draw_char(draw_item_t it);
            int sc, top, left, x, y, fs;
            logic [6:0] g;
            x = int'(it.x);
            y = int'(it.y);
            fs = int'(it.sa);
            sc = fs / 8;
            if (sc < 1) sc = 1;
            top = y - fs;
            left = x + int'(it.slot) * 8 * sc;
            g = loaded[it.code] ? it.code : sgr_pkg::FALLBACK_CHAR;
            for (int r = 0; r < 8; r++)
                for (int b = 0; b < 8; b++)
                    if (glyph[g*8 + r][7-b])
                        fill_box(left + b*sc, top + r*sc, sc, sc);
        endfunction

        function logic [63:0] canvas_fnv();
            logic [63:0] h;
            h = sgr_pkg::FNV_BASIS;
            for (int yy = 0; yy < act_h(); yy++)
                for (int xx = 0; xx < act_w(); xx++)
                    h = (h ^ {63'd0, pix[yy*sgr_pkg::MAX_WIDTH + xx]}) * 64'h100000001b3;
            return h;
        endfunction

        function void note_item(draw_item_t it);
            sgr_pkg::res_t r;
            int x, y;
            r = '0;
            x = int'(it.x);
            y = int'(it.y);
            case (it.req)
                sgr_pkg::REQ_CLEAR:  foreach (pix[i]) pix[i] = 1'b0;
                sgr_pkg::REQ_RECT:   fill_box(x, y, int'(it.sa), int'(it.sb));
                sgr_pkg::REQ_CIRCLE: fill_disc(x, y, int'(it.sa));
                sgr_pkg::REQ_CHAR:   draw_char(it);
                sgr_pkg::REQ_LOAD:
                begin
                    glyph[it.code*8 + it.row] = it.bits;
                    loaded[it.code] = 1'b1;
                end
                sgr_pkg::REQ_READ:
                    if (x >= 0 && y >= 0 && x < act_w() && y < act_h())
                        r.pixel_value = pix[y*sgr_pkg::MAX_WIDTH + x];
                sgr_pkg::REQ_HASH:
                    if (act_w() == 0 || act_h() == 0) r.status = 1'b1;
                    else r.canvas_hash = canvas_fnv();
                default: ;
            endcase
            owed_q.push_back(r);
        endfunction

        function void fail_note(string msg);
            if (errors < MAX_SHOWN) $display("mismatch: %s", msg);
            errors++;
        endfunction

        function void check_result(logic pv, logic [63:0] h, logic st);
            sgr_pkg::res_t w;
            if (owed_q.size() == 0)
            begin
                fail_note("result arrived with nothing owed");
                return;
            end
            w = owed_q.pop_front();
            if (pv !== w.pixel_value)
                fail_note($sformatf("pixel_value exp %0b got %0b", w.pixel_value, pv));
            if (h !== w.canvas_hash)
                fail_note($sformatf("canvas_hash exp %h got %h", w.canvas_hash, h));
            if (st !== w.status)
                fail_note($sformatf("status exp %0b got %0b", w.status, st));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic push = 1'b0;
    logic full;
    logic [2:0] req_type = '0;
    logic signed [11:0] pos_x = '0, pos_y = '0;
    logic [10:0] size_a = '0, size_b = '0;
    logic [6:0] char_code = '0, char_slot = '0;
    logic [2:0] glyph_row_index = '0;
    logic [7:0] glyph_row_bits = '0;
    logic empty;
    logic pop = 1'b0;
    logic pixel_value;
    logic [63:0] canvas_hash;
    logic status;

    canvas_scoreboard sb = new();
    bit calm = 1'b0;         // when set neither side idles
    int stall_cycles = 0;

    shape_and_glyph_rasterizer_core u_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: check every popped item, then pick pop for the next edge
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(pixel_value, canvas_hash, status);
        pop <= calm || ($urandom_range(0, 99) >= 24);
    end

    // watchdog on cycles without any handshake; covers the post-reset clearing pass
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // apb write: setup cycle then access cycle, done once pready is seen
    task automatic write_reg(logic [2:0] addr, int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_WIDTH_REG) sb.reg_w = int'(value & 32'h7ff);
        else sb.reg_h = int'(value & 32'h3ff);
    endtask

    // push stays high from one item to the next; only idle cycles and drain lower it
    task automatic send(draw_item_t it);
        while (!calm && $urandom_range(0, 99) < 24)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        req_type <= it.req;
        pos_x <= it.x;
        pos_y <= it.y;
        size_a <= it.sa;
        size_b <= it.sb;
        char_code <= it.code;
        char_slot <= it.slot;
        glyph_row_index <= it.row;
        glyph_row_bits <= it.bits;
        do @(posedge clk); while (full);
        sb.note_item(it);
    endtask

    // wait for every owed result, then a margin so the block is idle
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (sb.owed_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic draw_item_t mk(logic [2:0] req, int x, int y, int sa,
                                      int sbv = 0, int code = 0, int slot = 0,
                                      int row = 0, int bits = 0);
        draw_item_t it;
        it.req = req;
        it.x = 12'(x);
        it.y = 12'(y);
        it.sa = 11'(sa);
        it.sb = 11'(sbv);
        it.code = 7'(code);
        it.slot = 7'(slot);
        it.row = 3'(row);
        it.bits = 8'(bits);
        return it;
    endfunction

    // random item; 'roomy' keeps shapes tiny so the full-size canvas stays cheap
    function automatic draw_item_t rand_item(int w, int h, bit roomy);
        draw_item_t it;
        int k, lim;
        logic [6:0] few [5] = '{7'h3f, 7'h41, 7'h42, 7'h43, 7'h00};
        k = $urandom_range(0, 99);
        it.req = k < 2 ? sgr_pkg::REQ_CLEAR : k < 20 ? sgr_pkg::REQ_RECT :
                 k < 34 ? sgr_pkg::REQ_CIRCLE : k < 52 ? sgr_pkg::REQ_CHAR :
                 k < 68 ? sgr_pkg::REQ_LOAD : k < 88 ? sgr_pkg::REQ_READ :
                 k < 95 ? sgr_pkg::REQ_HASH : REQ_IDLE_CODE;
        if (roomy && (it.req == sgr_pkg::REQ_HASH || it.req == sgr_pkg::REQ_CLEAR))
            it.req = sgr_pkg::REQ_READ;
        it.x = 12'($urandom);
        it.y = 12'($urandom);
        it.sa = 11'($urandom);
        it.sb = 11'($urandom);
        it.code = 7'($urandom);
        it.slot = 7'($urandom);
        it.row = 3'($urandom);
        it.bits = 8'($urandom);
        lim = roomy ? 24 : w + 4;
        if (roomy || $urandom_range(0, 9) != 0)
        begin
            // well-formed: near the canvas, modest sizes, mostly known glyphs
            it.x = 12'($urandom_range(0, w + 16) - 8);
            it.y = 12'($urandom_range(0, h + 16) - 8);
            it.sa = 11'($urandom_range(0, lim));
            it.sb = 11'($urandom_range(0, lim));
            if (it.req == sgr_pkg::REQ_CHAR)
            begin
                it.sa = 11'($urandom_range(0, roomy ? 24 : 32));
                it.y = it.y + 12'(it.sa);
                it.slot = 7'($urandom_range(0, 5));
            end
            if ($urandom_range(0, 9) < 6) it.code = few[$urandom_range(0, 4)];
        end
        return it;
    endfunction

    initial
    begin
        draw_item_t d [$];
        // reset: held low, then released
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero-sized canvas right after reset: hash refused, reads give 0
        d = '{mk(sgr_pkg::REQ_HASH, 0, 0, 0), mk(sgr_pkg::REQ_READ, 0, 0, 0),
              mk(sgr_pkg::REQ_RECT, 0, 0, 5, 5),
              mk(REQ_IDLE_CODE, -1, -1, 2047, 2047, 127, 127, 7, 255)};
        foreach (d[i]) send(d[i]);
        drain();

        write_reg(ADDR_WIDTH_REG, 40);
        write_reg(ADDR_HEIGHT_REG, 24);
        d = '{
            // glyph absent and fallback never loaded: draws blank
            mk(sgr_pkg::REQ_CHAR, 0, 10, 8, 0, 65, 0),
            mk(sgr_pkg::REQ_LOAD, 0, 0, 0, 0, 63, 0, 0, 8'h3c),
            mk(sgr_pkg::REQ_LOAD, 0, 0, 0, 0, 63, 0, 7, 8'hff),
            mk(sgr_pkg::REQ_LOAD, 0, 0, 0, 0, 127, 0, 3, 8'h81),
            mk(sgr_pkg::REQ_LOAD, 0, 0, 0, 0, 0, 0, 0, 8'h80),
            // absent glyph falls back to '?'
            mk(sgr_pkg::REQ_CHAR, 2, 8, 8, 0, 66, 0),
            mk(sgr_pkg::REQ_CHAR, 0, 20, 0, 0, 127, 1),
            mk(sgr_pkg::REQ_CHAR, -2048, 2047, 2047, 0, 0, 127),
            mk(sgr_pkg::REQ_CHAR, 0, 2047, 2047, 0, 63, 0),
            mk(sgr_pkg::REQ_HASH, 0, 0, 0),
            mk(sgr_pkg::REQ_CLEAR, 0, 0, 0),
            mk(sgr_pkg::REQ_RECT, -2048, -2048, 2047, 2047),
            mk(sgr_pkg::REQ_READ, 39, 23, 0),
            mk(sgr_pkg::REQ_READ, 40, 0, 0),
            mk(sgr_pkg::REQ_READ, -1, 5, 0),
            mk(sgr_pkg::REQ_CLEAR, 0, 0, 0),
            mk(sgr_pkg::REQ_RECT, 5, 5, 0, 7),
            mk(sgr_pkg::REQ_CIRCLE, 20, 12, 0),
            mk(sgr_pkg::REQ_CIRCLE, 2047, 2047, 2047),
            mk(sgr_pkg::REQ_CIRCLE, 10, 10, 6),
            mk(sgr_pkg::REQ_HASH, 0, 0, 0),
            mk(REQ_IDLE_CODE, 3, 3, 3, 3)};
        foreach (d[i]) send(d[i]);

        for (int n = 0; n < 240; n++)
        begin
            calm = (n >= 100 && n < 170);
            send(rand_item(40, 24, 1'b0));
        end
        calm = 1'b0;
        drain();

        write_reg(ADDR_WIDTH_REG, 16);
        write_reg(ADDR_HEIGHT_REG, 9);
        for (int n = 0; n < 150; n++)
        begin
            if (n == 75) drain();   // sender holds off until the block is empty
            send(rand_item(16, 9, 1'b0));
        end
        drain();

        // full canvas: tiny shapes, one near the far edge, one whole-canvas hash
        write_reg(ADDR_WIDTH_REG, 1024);
        write_reg(ADDR_HEIGHT_REG, 512);
        send(mk(sgr_pkg::REQ_RECT, 1018, 506, 20, 20));
        send(mk(sgr_pkg::REQ_READ, 1023, 511, 0));
        for (int n = 0; n < 12; n++) send(rand_item(1024, 512, 1'b1));
        send(mk(sgr_pkg::REQ_HASH, 0, 0, 0));
        drain();

        // registers above the maximum saturate
        write_reg(ADDR_WIDTH_REG, 2047);
        write_reg(ADDR_HEIGHT_REG, 1023);
        send(mk(sgr_pkg::REQ_CIRCLE, 1023, 511, 4));
        send(mk(sgr_pkg::REQ_READ, 1023, 510, 0));
        send(mk(sgr_pkg::REQ_READ, 1024, 0, 0));
        for (int n = 0; n < 10; n++) send(rand_item(1024, 512, 1'b1));
        drain();

        // zero width with nonzero height
        write_reg(ADDR_WIDTH_REG, 0);
        write_reg(ADDR_HEIGHT_REG, 5);
        for (int n = 0; n < 15; n++) send(rand_item(8, 5, 1'b1));
        send(mk(sgr_pkg::REQ_HASH, 0, 0, 0));
        drain();

        write_reg(ADDR_WIDTH_REG, 33);
        write_reg(ADDR_HEIGHT_REG, 17);
        send(mk(sgr_pkg::REQ_CLEAR, 0, 0, 0));
        for (int n = 0; n < 130; n++) send(rand_item(33, 17, 1'b0));
        send(mk(sgr_pkg::REQ_HASH, 0, 0, 0));
        drain();

        if (sb.errors == 0 && sb.owed_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
